FILE: design/met_pkg.sv
// ---------------------------------------------------------------------------
// met_pkg
// Shared types and constants for the escape-time pixel engine.
// ---------------------------------------------------------------------------
package met_pkg;

   // Fixed-point format: signed Q4.28 coordinates
   localparam int FRAC_BITS = 28;
   localparam int COORD_W   = 32;
   localparam int ITER_W    = 16;

   // z components stay within +/-2.0 once accepted: 31 signed bits
   localparam int Z_W = FRAC_BITS + 3;
   // full-width products of two z components
   localparam int P_W = 2 * Z_W;
   // new z component before the range check: up to +/-2^31 plus a full coordinate
   localparam int N_W = COORD_W + 4;

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_X_MIN    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_Y_MIN    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_X_STEP   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_Y_STEP   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MAX_ITER = 3'd4;

   // Register reset values
   localparam logic signed [COORD_W-1:0] RST_X_MIN    = -32'sd536870912;
   localparam logic signed [COORD_W-1:0] RST_Y_MIN    = -32'sd300647711;
   localparam logic signed [COORD_W-1:0] RST_X_STEP   = 32'sd663699;
   localparam logic signed [COORD_W-1:0] RST_Y_STEP   = 32'sd601897;
   localparam logic [ITER_W-1:0]         RST_MAX_ITER = 16'd100;

   // Default structure sizes
   localparam int DEF_INDEX_BITS  = 14;
   localparam int DEF_QUEUE_DEPTH = 2;

   // One mapped point, handed from the front end to the iteration engine
   typedef struct packed {
      logic signed [COORD_W-1:0] re;
      logic signed [COORD_W-1:0] im;
   } coord_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_DONE
   } state_type;

endpackage

FILE: design/met_queue.sv
// ---------------------------------------------------------------------------
// met_queue
// Small register FIFO of mapped points between front end and engine.
// ---------------------------------------------------------------------------
module met_queue
   import met_pkg::*;
#(
   parameter int DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  coord_type wr_data,
   output logic      full,
   input  logic      rd_en,
   output coord_type rd_data,
   output logic      valid
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   coord_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign valid   = (cnt_ff != '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: design/met_front.sv
// ---------------------------------------------------------------------------
// met_front
// Pixel front end: maps column/row to a saturated Q4.28 point.
// ---------------------------------------------------------------------------
module met_front
   import met_pkg::*;
#(
   parameter int INDEX_BITS = DEF_INDEX_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic [INDEX_BITS-1:0]     column_index,
   input  logic [INDEX_BITS-1:0]     row_index,
   input  logic signed [COORD_W-1:0] x_min,
   input  logic signed [COORD_W-1:0] y_min,
   input  logic signed [COORD_W-1:0] x_step,
   input  logic signed [COORD_W-1:0] y_step,
   output logic                      q_push,
   output coord_type                 q_data,
   input  logic                      q_full
);

   localparam int PW = INDEX_BITS + COORD_W + 1;
   localparam int SW = PW + 1;
   localparam logic signed [SW-1:0] SAT_HI = SW'(64'sd2147483647);
   localparam logic signed [SW-1:0] SAT_LO = SW'(-64'sd2147483648);

   logic                 s1_valid_ff, s1_valid_in;
   logic signed [PW-1:0] prod_x_ff, prod_x_in;
   logic signed [PW-1:0] prod_y_ff, prod_y_in;
   logic signed [SW-1:0] sum_x, sum_y;
   logic                 accept;
   logic                 advance;

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SW-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[COORD_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   // stage 1: index * step, stage 2: + base and clamp into the queue
   assign advance = !s1_valid_ff || !q_full;
   assign full    = !advance;
   assign accept  = push && advance;

   assign prod_x_in = PW'($signed({1'b0, column_index})) * PW'(x_step);
   assign prod_y_in = PW'($signed({1'b0, row_index})) * PW'(y_step);

   assign sum_x = $signed({prod_x_ff[PW-1], prod_x_ff})
                + $signed({{(SW-COORD_W){x_min[COORD_W-1]}}, x_min});
   assign sum_y = $signed({prod_y_ff[PW-1], prod_y_ff})
                + $signed({{(SW-COORD_W){y_min[COORD_W-1]}}, y_min});

   assign q_push    = s1_valid_ff && !q_full;
   assign q_data.re = sat32(sum_x);
   assign q_data.im = sat32(sum_y);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (advance) begin
         s1_valid_in = accept;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
      end
   end

endmodule

FILE: design/met_iter.sv
// ---------------------------------------------------------------------------
// met_iter
// Iteration engine: z = z^2 + c, a multiply step and an add/compare step per iteration, result slot.
// ---------------------------------------------------------------------------
module met_iter
   import met_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [ITER_W-1:0] max_iter,
   input  logic              q_valid,
   input  coord_type         q_data,
   output logic              q_pop,
   input  logic              pop,
   output logic              empty,
   output logic [ITER_W-1:0] escape_count
);

   localparam logic signed [P_W:0]   FOUR_P = (P_W + 1)'(1) << (2 * FRAC_BITS + 2);
   localparam logic signed [N_W-1:0] TWO_N  = N_W'(1) << (FRAC_BITS + 1);
   localparam logic signed [N_W-1:0] MTWO_N = -TWO_N;

   state_type state_ff, state_in;

   logic signed [COORD_W-1:0] cr_ff, cr_in, ci_ff, ci_in;
   logic signed [Z_W-1:0]     zr_ff, zr_in, zi_ff, zi_in;
   logic signed [P_W-1:0]     rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic [ITER_W-1:0]         it_ff, it_in;
   logic [ITER_W-1:0]         count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ITER_W-1:0]         rsp_count_ff, rsp_count_in;

   logic signed [P_W:0]   mag, diff, diff_sh;
   logic signed [P_W-1:0] ri_sh;
   logic signed [N_W-1:0] nr, ni;
   logic                  esc_mag, at_limit, esc_rng, finish, slot_free;

   // |z|^2 of the current z comes from this iteration's squares
   assign mag     = $signed({rr_ff[P_W-1], rr_ff}) + $signed({ii_ff[P_W-1], ii_ff});
   assign diff    = $signed({rr_ff[P_W-1], rr_ff}) - $signed({ii_ff[P_W-1], ii_ff});
   assign diff_sh = diff >>> FRAC_BITS;
   assign ri_sh   = ri_ff >>> (FRAC_BITS - 1);   // floor(2*zr*zi / 2^28)

   assign nr = $signed(diff_sh[N_W-1:0])
             + $signed({{(N_W-COORD_W){cr_ff[COORD_W-1]}}, cr_ff});
   assign ni = $signed(ri_sh[N_W-1:0])
             + $signed({{(N_W-COORD_W){ci_ff[COORD_W-1]}}, ci_ff});

   assign esc_mag  = (it_ff != '0) && (mag > FOUR_P);
   assign at_limit = (it_ff == max_iter);
   assign esc_rng  = (nr > TWO_N) || (nr < MTWO_N) || (ni > TWO_N) || (ni < MTWO_N);
   assign finish   = esc_mag || at_limit || esc_rng;

   assign slot_free    = !rsp_valid_ff || pop;
   assign empty        = !rsp_valid_ff;
   assign escape_count = rsp_count_ff;
   assign q_pop        = (state_ff == ST_IDLE) && q_valid;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            state_in = finish ? ST_DONE : ST_MUL;
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath updates
   always_comb begin
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      rr_in        = rr_ff;
      ii_in        = ii_ff;
      ri_in        = ri_ff;
      it_in        = it_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cr_in = q_data.re;
               ci_in = q_data.im;
               zr_in = '0;
               zi_in = '0;
               it_in = '0;
            end
         end
         ST_MUL: begin
            rr_in = P_W'(zr_ff) * P_W'(zr_ff);
            ii_in = P_W'(zi_ff) * P_W'(zi_ff);
            ri_in = P_W'(zr_ff) * P_W'(zi_ff);
         end
         ST_ADD: begin
            if (esc_mag) begin
               count_in = it_ff;
            end else if (at_limit) begin
               count_in = max_iter;
            end else if (esc_rng) begin
               count_in = it_ff + ITER_W'(1);
            end else begin
               zr_in = nr[Z_W-1:0];
               zi_in = ni[Z_W-1:0];
               it_in = it_ff + ITER_W'(1);
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cr_ff        <= cr_in;
      ci_ff        <= ci_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      rr_ff        <= rr_in;
      ii_ff        <= ii_in;
      ri_ff        <= ri_in;
      it_ff        <= it_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
   end

endmodule

FILE: design/mandelbrot_escape_time_unit.sv
// ---------------------------------------------------------------------------
// mandelbrot_escape_time_unit
// Escape-time pixel engine: one pixel in, one iteration count out.
// ---------------------------------------------------------------------------
//
//  channel   ports                               beat
//  -------   ---------------------------------   ------------------------------
//  req       push/full, req_column_index,        one pixel (column, row)
//            req_row_index
//  rsp       empty/pop, rsp_escape_count         escape count of one pixel
//  csr       psel/penable/pwrite/paddr/pwdata/   32-bit register write / read
//            prdata/pready
//
//  Sequence: the engine loads a point, runs each iteration as a multiply
//  step (the 31x31 products) and then an add/compare step, and hands off
//  the count. It takes a new point only after the count has gone to the
//  result slot; the front end maps the next pixel meanwhile.
//  Reset: synchronous, clears the point queue, engine state and the result slot; the
//  registers return to the default view (x from -2.0, y from about -1.12,
//  100 iterations).
//  Stalls: a waiting result blocks only the engine's last step; the front
//  end and the point queue keep taking beats until the queue fills.
//
module mandelbrot_escape_time_unit
   import met_pkg::*;
#(
   parameter int INDEX_BITS  = DEF_INDEX_BITS,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  push,
   output logic                  full,
   input  logic [INDEX_BITS-1:0] req_column_index,
   input  logic [INDEX_BITS-1:0] req_row_index,
   // result channel
   output logic                  empty,
   input  logic                  pop,
   output logic [ITER_W-1:0]     rsp_escape_count,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // configuration registers
   logic signed [COORD_W-1:0] x_min_ff, x_min_in;
   logic signed [COORD_W-1:0] y_min_ff, y_min_in;
   logic signed [COORD_W-1:0] x_step_ff, x_step_in;
   logic signed [COORD_W-1:0] y_step_ff, y_step_in;
   logic [ITER_W-1:0]         max_iter_ff, max_iter_in;

   logic [REG_IDX_W-1:0] reg_idx;
   logic                 csr_write;

   // front end -> queue -> engine
   coord_type q_wr_data, q_rd_data;
   logic      q_push, q_full, q_pop, q_valid;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   // register write decode; indexes past the list are dropped
   always_comb begin
      x_min_in    = x_min_ff;
      y_min_in    = y_min_ff;
      x_step_in   = x_step_ff;
      y_step_in   = y_step_ff;
      max_iter_in = max_iter_ff;
      if (csr_write) begin
         case (reg_idx)
            REG_X_MIN:    x_min_in    = pwdata;
            REG_Y_MIN:    y_min_in    = pwdata;
            REG_X_STEP:   x_step_in   = pwdata;
            REG_Y_STEP:   y_step_in   = pwdata;
            REG_MAX_ITER: max_iter_in = pwdata[ITER_W-1:0];
            default: begin
               x_min_in = x_min_ff;
            end
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_X_MIN:    prdata = x_min_ff;
         REG_Y_MIN:    prdata = y_min_ff;
         REG_X_STEP:   prdata = x_step_ff;
         REG_Y_STEP:   prdata = y_step_ff;
         REG_MAX_ITER: prdata = {{(CSR_DATA_W-ITER_W){1'b0}}, max_iter_ff};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff    <= RST_X_MIN;
         y_min_ff    <= RST_Y_MIN;
         x_step_ff   <= RST_X_STEP;
         y_step_ff   <= RST_Y_STEP;
         max_iter_ff <= RST_MAX_ITER;
      end else begin
         x_min_ff    <= x_min_in;
         y_min_ff    <= y_min_in;
         x_step_ff   <= x_step_in;
         y_step_ff   <= y_step_in;
         max_iter_ff <= max_iter_in;
      end
   end

   // pixel -> complex point
   met_front #(
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .column_index (req_column_index),
      .row_index    (req_row_index),
      .x_min        (x_min_ff),
      .y_min        (y_min_ff),
      .x_step       (x_step_ff),
      .y_step       (y_step_ff),
      .q_push       (q_push),
      .q_data       (q_wr_data),
      .q_full       (q_full)
   );

   // decoupling queue of mapped points
   met_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_rd_data),
      .valid   (q_valid)
   );

   // escape-time iteration and result slot
   met_iter u_iter (
      .clock        (clock),
      .reset        (reset),
      .max_iter     (max_iter_ff),
      .q_valid      (q_valid),
      .q_data       (q_rd_data),
      .q_pop        (q_pop),
      .pop          (pop),
      .empty        (empty),
      .escape_count (rsp_escape_count)
   );

   // the front end never writes a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("point queue written while full");

   // the engine only takes a point that is there
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("point queue read while empty");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result pending right after reset");

   // a request stalled by the front end is not lost: full only with a busy queue
   a_full_cause: assert property (@(posedge clock) disable iff (reset)
      full |-> q_full)
      else $error("front end stalled with room in the queue");

endmodule
